### rtl/core/mbup_pkg.sv
// ----------------------------------------------------------------------------
// mbup_pkg
// Shared types and codes for the MIDI byte to USB-MIDI packetiser.
// ----------------------------------------------------------------------------
package mbup_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_nibble;

    // MIDI status bytes with special handling
    localparam t_byte ST_SYSEX_START = 8'hF0;
    localparam t_byte ST_MTC_QFRAME  = 8'hF1;
    localparam t_byte ST_SONG_POS    = 8'hF2;
    localparam t_byte ST_SONG_SEL    = 8'hF3;
    localparam t_byte ST_TUNE_REQ    = 8'hF6;
    localparam t_byte ST_SYSEX_END   = 8'hF7;
    localparam t_byte ST_REALTIME    = 8'hF8;
    localparam t_byte ST_RT_UNDEF_A  = 8'hF9;
    localparam t_byte ST_RT_UNDEF_B  = 8'hFD;

    // status upper nibbles of two-byte channel messages
    localparam t_nibble HI_PROG_CHANGE = 4'hC;
    localparam t_nibble HI_CHAN_PRESS  = 4'hD;

    // USB-MIDI code index numbers
    localparam t_nibble CIN_COMMON_2B  = 4'h2;
    localparam t_nibble CIN_COMMON_3B  = 4'h3;
    localparam t_nibble CIN_SYSEX      = 4'h4;
    localparam t_nibble CIN_SYSEX_END1 = 4'h5;
    localparam t_nibble CIN_REALTIME   = 4'hF;

    typedef struct packed {
        t_nibble code_index;
        t_byte   byte_one;
        t_byte   byte_two;
        t_byte   byte_three;
    } t_pkt;

endpackage

### rtl/core/mbup_in_stage.sv
// ----------------------------------------------------------------------------
// mbup_in_stage
// Input register: holds one received MIDI byte until the parser takes it.
// ----------------------------------------------------------------------------
module mbup_in_stage
    import mbup_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_byte i_byte,
    input  logic  i_take,
    output logic  o_valid,
    output t_byte o_byte
);

    logic  r_valid;
    t_byte r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

### rtl/core/mbup_parser.sv
// ----------------------------------------------------------------------------
// mbup_parser
// Running-status / SysEx state and per-byte classification into packets.
// ----------------------------------------------------------------------------
module mbup_parser
    import mbup_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_byte i_byte,
    output logic  o_emit,
    output t_pkt  o_pkt
);

    t_byte      r_rs;
    logic [1:0] r_len;
    logic [1:0] r_fill;
    logic       r_sysex;
    t_nibble    r_code;
    t_byte      r_pb [3];

    t_byte      n_rs;
    logic [1:0] n_len;
    logic [1:0] n_fill;
    logic       n_sysex;
    t_nibble    n_code;
    t_byte      n_pb [3];

    logic       w_rt;
    logic [1:0] w_cnt;
    t_nibble    w_code;
    logic [1:0] w_f;
    logic [1:0] w_nf;

    always_comb begin
        n_rs    = r_rs;
        n_len   = r_len;
        n_fill  = r_fill;
        n_sysex = r_sysex;
        n_code  = r_code;
        n_pb    = r_pb;
        o_emit  = 1'b0;
        w_rt    = 1'b0;
        w_cnt   = 2'd0;
        w_code  = r_code;
        w_f     = r_fill;
        w_nf    = r_fill;

        if (i_byte >= ST_REALTIME) begin
            if (i_byte != ST_RT_UNDEF_A && i_byte != ST_RT_UNDEF_B) begin
                o_emit = 1'b1;
                w_rt   = 1'b1;
                w_code = CIN_REALTIME;
            end
        end else if (i_byte[7]) begin
            n_rs    = '0;
            n_len   = '0;
            n_fill  = '0;
            n_sysex = 1'b0;
            n_code  = '0;
            if (i_byte == ST_SYSEX_START) begin
                n_sysex  = 1'b1;
                n_code   = CIN_SYSEX;
                n_pb[0]  = ST_SYSEX_START;
                n_fill   = 2'd1;
            end else if (i_byte == ST_SYSEX_END) begin
                if (r_sysex && r_fill != 2'd3) begin
                    n_pb[r_fill] = ST_SYSEX_END;
                    o_emit = 1'b1;
                    w_code = CIN_SYSEX_END1 + {2'b00, r_fill};
                    w_cnt  = r_fill + 2'd1;
                end
            end else if (!i_byte[4] || i_byte == ST_MTC_QFRAME || i_byte == ST_SONG_SEL
                         || i_byte == ST_SONG_POS) begin
                n_rs    = i_byte;
                n_pb[0] = i_byte;
                n_fill  = 2'd1;
                if (!i_byte[4] && i_byte[6:4] != 3'b111) begin
                    // channel message
                    n_code = i_byte[7:4];
                    n_len  = (i_byte[7:4] == HI_PROG_CHANGE ||
                              i_byte[7:4] == HI_CHAN_PRESS) ? 2'd2 : 2'd3;
                end else if (i_byte[7:4] != 4'hF) begin
                    n_code = i_byte[7:4];
                    n_len  = (i_byte[7:4] == HI_PROG_CHANGE ||
                              i_byte[7:4] == HI_CHAN_PRESS) ? 2'd2 : 2'd3;
                end else if (i_byte == ST_SONG_POS) begin
                    n_code = CIN_COMMON_3B;
                    n_len  = 2'd3;
                end else begin
                    n_code = CIN_COMMON_2B;
                    n_len  = 2'd2;
                end
            end else if (i_byte < ST_SYSEX_START) begin
                // channel status with bit 4 set
                n_rs    = i_byte;
                n_pb[0] = i_byte;
                n_fill  = 2'd1;
                n_code  = i_byte[7:4];
                n_len   = (i_byte[7:4] == HI_PROG_CHANGE ||
                           i_byte[7:4] == HI_CHAN_PRESS) ? 2'd2 : 2'd3;
            end else if (i_byte == ST_TUNE_REQ) begin
                n_pb[0] = i_byte;
                o_emit  = 1'b1;
                w_code  = CIN_SYSEX_END1;
                w_cnt   = 2'd1;
            end
        end else if (r_sysex) begin
            w_f       = (r_fill == 2'd3) ? 2'd0 : r_fill;
            n_pb[w_f] = i_byte;
            w_nf      = w_f + 2'd1;
            n_fill    = w_nf;
            if (w_nf == 2'd3) begin
                n_fill = 2'd0;
                o_emit = 1'b1;
                w_code = CIN_SYSEX;
                w_cnt  = 2'd3;
            end
        end else if (r_rs != '0) begin
            w_f = r_fill;
            if (w_f == 2'd0) begin
                n_pb[0] = r_rs;
                w_f     = 2'd1;
            end
            if (w_f == 2'd3 || r_len < 2'd2) begin
                n_rs    = '0;
                n_len   = '0;
                n_fill  = '0;
                n_sysex = 1'b0;
                n_code  = '0;
            end else begin
                n_pb[w_f] = i_byte;
                w_nf      = w_f + 2'd1;
                n_fill    = w_nf;
                if (w_nf >= r_len) begin
                    n_fill = 2'd0;
                    o_emit = 1'b1;
                    w_code = r_code;
                    w_cnt  = r_len;
                    if (r_rs >= ST_SYSEX_START) begin
                        n_rs    = '0;
                        n_len   = '0;
                        n_sysex = 1'b0;
                        n_code  = '0;
                    end
                end
            end
        end

        o_pkt.code_index = w_code;
        if (w_rt) begin
            o_pkt.byte_one   = i_byte;
            o_pkt.byte_two   = '0;
            o_pkt.byte_three = '0;
        end else begin
            o_pkt.byte_one   = (w_cnt > 2'd0) ? n_pb[0] : '0;
            o_pkt.byte_two   = (w_cnt > 2'd1) ? n_pb[1] : '0;
            o_pkt.byte_three = (w_cnt > 2'd2) ? n_pb[2] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs    <= '0;
            r_len   <= '0;
            r_fill  <= '0;
            r_sysex <= 1'b0;
            r_code  <= '0;
            r_pb    <= '{default: '0};
        end else if (i_step) begin
            r_rs    <= n_rs;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_sysex <= n_sysex;
            r_code  <= n_code;
            r_pb    <= n_pb;
        end
    end

endmodule

### rtl/core/midi_byte_to_usb_midi_packet.sv
// ----------------------------------------------------------------------------
// midi_byte_to_usb_midi_packet
// Serial MIDI byte stream to USB-MIDI event packet converter.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per clock cycle when the packet side keeps up; a byte
// passes an input register, is classified combinationally against the running
// status / SysEx state, and any resulting packet is loaded into the output
// register as the byte is taken. Bytes that complete no packet (data of an
// unfinished message, SysEx start, dropped status) yield no output item.
// The cable number register must be written only while no item is in flight.
module midi_byte_to_usb_midi_packet
    import mbup_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_midi_valid,
    output logic       o_midi_ready,
    input  logic [7:0] i_midi_byte,
    output logic       o_pkt_valid,
    input  logic       i_pkt_ready,
    output logic [3:0] o_cable,
    output logic [3:0] o_code_index,
    output logic [7:0] o_byte_one,
    output logic [7:0] o_byte_two,
    output logic [7:0] o_byte_three,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_cable_number
);

    logic    w_in_valid;
    t_byte   w_in_byte;
    logic    w_take;
    logic    w_emit;
    t_pkt    w_pkt;
    logic    w_out_free;

    logic    r_out_valid;
    t_pkt    r_pkt;
    t_nibble r_pkt_cable;
    t_nibble r_cable;

    assign w_out_free = !r_out_valid || i_pkt_ready;
    assign w_take     = w_in_valid && w_out_free;

    mbup_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_midi_valid),
        .o_ready (o_midi_ready),
        .i_byte  (i_midi_byte),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    mbup_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_take),
        .i_byte  (w_in_byte),
        .o_emit  (w_emit),
        .o_pkt   (w_pkt)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cable <= '0;
        end else if (i_cfg_valid) begin
            r_cable <= i_cfg_cable_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pkt_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_pkt       <= w_pkt;
            r_pkt_cable <= r_cable;
        end
    end

    assign o_pkt_valid  = r_out_valid;
    assign o_cable      = r_pkt_cable;
    assign o_code_index = r_pkt.code_index;
    assign o_byte_one   = r_pkt.byte_one;
    assign o_byte_two   = r_pkt.byte_two;
    assign o_byte_three = r_pkt.byte_three;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_pkt_valid)
        else $error("packet valid after reset");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pkt_valid && !i_pkt_ready) |=> (o_pkt_valid && $stable(r_pkt)))
        else $error("pending packet overwritten");

    a_rt_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pkt_valid && o_code_index == CIN_REALTIME) |->
        (o_byte_two == '0 && o_byte_three == '0 && o_byte_one >= ST_REALTIME))
        else $error("malformed real-time packet");

    a_common2_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pkt_valid && o_code_index == CIN_COMMON_2B) |-> (o_byte_three == '0))
        else $error("two-byte common packet carries third byte");
`endif

endmodule

### verif/tb_midi_byte_to_usb_midi_packet.sv
// ----------------------------------------------------------------------------
// tb_midi_byte_to_usb_midi_packet
// Self-checking bench for the MIDI byte to USB-MIDI packetiser. A short
// scripted byte stream runs straight after reset, then randomised phrases
// (channel messages with running status, system common, SysEx, real-time
// interjections and junk) run under several cable numbers. Each packet is
// compared field by field with a local parser model or a fixed script entry.
// ----------------------------------------------------------------------------
module tb_midi_byte_to_usb_midi_packet;
    import mbup_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT        = 8;
    localparam int          HOLD_CYCLES     = 150;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          NUM_PHASES      = 5;
    localparam int unsigned ITEMS_PER_PHASE = 160;
    localparam int          SCRIPT_LEN      = 29;
    localparam t_nibble     CIN_NOTE_ON     = 4'h9;
    localparam t_byte       NO_STATUS       = 8'h00;

    typedef struct packed {
        t_nibble cable;
        t_pkt    pkt;
    } t_usb_event;

    typedef struct packed {
        t_byte midi;
        bit    fixed;
        bit    fixed_hit;
        t_pkt  want;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       midi_valid   = 1'b0;
    logic [7:0] midi_byte    = 8'h00;
    logic       pkt_ready    = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic [3:0] cfg_cable    = 4'h0;
    logic       o_midi_ready;
    logic       o_pkt_valid;
    logic       o_cfg_ready;
    logic [3:0] o_cable;
    logic [3:0] o_code_index;
    logic [7:0] o_byte_one;
    logic [7:0] o_byte_two;
    logic [7:0] o_byte_three;

    // parser model state
    t_nibble    cable_cfg;
    t_byte      run_status;
    logic [1:0] msg_len;
    logic [1:0] fill;
    bit         sysex_open;
    t_nibble    msg_cin;
    t_byte      held [3];

    t_usb_event  pending_events [$];
    t_byte       phrase [$];
    bit          steady   = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned errors, bytes_sent, phase_items, packets_seen, cable_writes;

    t_script_row script [SCRIPT_LEN] = '{
        '{ST_REALTIME,    1'b1, 1'b1, '{CIN_REALTIME, ST_REALTIME, 8'h00, 8'h00}},
        '{8'h90,          1'b0, 1'b0, '0},
        '{8'h00,          1'b0, 1'b0, '0},
        '{8'h7F,          1'b1, 1'b1, '{CIN_NOTE_ON, 8'h90, 8'h00, 8'h7F}},
        '{8'hFE,          1'b1, 1'b1, '{CIN_REALTIME, 8'hFE, 8'h00, 8'h00}},
        '{8'h7F,          1'b0, 1'b0, '0},
        '{8'h00,          1'b1, 1'b1, '{CIN_NOTE_ON, 8'h90, 8'h7F, 8'h00}},
        '{ST_RT_UNDEF_A,  1'b1, 1'b0, '0},
        '{ST_MTC_QFRAME,  1'b0, 1'b0, '0},
        '{8'h7F,          1'b1, 1'b1, '{CIN_COMMON_2B, ST_MTC_QFRAME, 8'h7F, 8'h00}},
        '{8'h7F,          1'b1, 1'b0, '0},
        '{ST_SONG_POS,    1'b0, 1'b0, '0},
        '{8'h01,          1'b0, 1'b0, '0},
        '{8'h02,          1'b0, 1'b0, '0},
        '{ST_TUNE_REQ,    1'b1, 1'b1, '{CIN_SYSEX_END1, ST_TUNE_REQ, 8'h00, 8'h00}},
        '{ST_SYSEX_START, 1'b0, 1'b0, '0},
        '{ST_SYSEX_END,   1'b0, 1'b0, '0},
        '{ST_SYSEX_START, 1'b0, 1'b0, '0},
        '{8'h11,          1'b0, 1'b0, '0},
        '{8'h22,          1'b0, 1'b0, '0},
        '{ST_SYSEX_END,   1'b1, 1'b1, '{CIN_SYSEX_END1, ST_SYSEX_END, 8'h00, 8'h00}},
        '{ST_SYSEX_START, 1'b0, 1'b0, '0},
        '{8'h33,          1'b0, 1'b0, '0},
        '{8'hB1,          1'b0, 1'b0, '0},
        '{8'h44,          1'b0, 1'b0, '0},
        '{8'hF4,          1'b0, 1'b0, '0},
        '{8'h55,          1'b0, 1'b0, '0},
        '{ST_SYSEX_END,   1'b0, 1'b0, '0},
        '{ST_RT_UNDEF_B,  1'b1, 1'b0, '0}
    };

    midi_byte_to_usb_midi_packet u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_midi_valid       (midi_valid),
        .o_midi_ready       (o_midi_ready),
        .i_midi_byte        (midi_byte),
        .o_pkt_valid        (o_pkt_valid),
        .i_pkt_ready        (pkt_ready),
        .o_cable            (o_cable),
        .o_code_index       (o_code_index),
        .o_byte_one         (o_byte_one),
        .o_byte_two         (o_byte_two),
        .o_byte_three       (o_byte_three),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_cable_number (cfg_cable)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("midi_byte_to_usb_midi_packet test failed");
        $finish;
    end

    function automatic void clear_message();
        run_status = NO_STATUS;
        msg_len    = 2'd0;
        fill       = 2'd0;
        sysex_open = 1'b0;
        msg_cin    = '0;
    endfunction

    function automatic t_usb_event pack_event(input t_nibble cin, input int unsigned count);
        t_usb_event ev;
        ev.cable          = cable_cfg;
        ev.pkt.code_index = cin;
        ev.pkt.byte_one   = count > 0 ? held[0] : 8'h00;
        ev.pkt.byte_two   = count > 1 ? held[1] : 8'h00;
        ev.pkt.byte_three = count > 2 ? held[2] : 8'h00;
        return ev;
    endfunction

    function automatic bit parse_midi_byte(input t_byte b, output t_usb_event ev);
        int unsigned count;
        t_nibble     cin;
        ev = '0;
        if (b >= ST_REALTIME) begin
            if (b == ST_RT_UNDEF_A || b == ST_RT_UNDEF_B) begin
                return 1'b0;
            end
            ev.cable          = cable_cfg;
            ev.pkt.code_index = CIN_REALTIME;
            ev.pkt.byte_one   = b;
            return 1'b1;
        end
        if (b[7]) begin
            if (b == ST_SYSEX_START) begin
                clear_message();
                sysex_open = 1'b1;
                msg_cin    = CIN_SYSEX;
                held[0]    = b;
                fill       = 2'd1;
                return 1'b0;
            end
            if (b == ST_SYSEX_END) begin
                if (sysex_open && fill < 2'd3) begin
                    held[fill] = b;
                    ev = pack_event(t_nibble'(CIN_SYSEX_END1 + fill), fill + 1);
                    clear_message();
                    return 1'b1;
                end
                clear_message();
                return 1'b0;
            end
            clear_message();
            if (b < ST_SYSEX_START) begin
                run_status = b;
                msg_len    = (b[7:4] == HI_PROG_CHANGE || b[7:4] == HI_CHAN_PRESS) ? 2'd2 : 2'd3;
                msg_cin    = b[7:4];
            end else if (b == ST_MTC_QFRAME || b == ST_SONG_SEL) begin
                run_status = b;
                msg_len    = 2'd2;
                msg_cin    = CIN_COMMON_2B;
            end else if (b == ST_SONG_POS) begin
                run_status = b;
                msg_len    = 2'd3;
                msg_cin    = CIN_COMMON_3B;
            end else if (b == ST_TUNE_REQ) begin
                // single-byte system common shares code 5
                held[0] = b;
                ev = pack_event(CIN_SYSEX_END1, 1);
                return 1'b1;
            end else begin
                return 1'b0;
            end
            held[0] = b;
            fill    = 2'd1;
            return 1'b0;
        end
        if (sysex_open) begin
            if (fill >= 2'd3) begin
                fill = 2'd0;
            end
            held[fill] = b;
            fill++;
            if (fill == 2'd3) begin
                fill = 2'd0;
                ev = pack_event(CIN_SYSEX, 3);
                return 1'b1;
            end
            return 1'b0;
        end
        if (run_status == NO_STATUS) begin
            return 1'b0;
        end
        if (fill == 2'd0) begin
            held[0] = run_status;
            fill    = 2'd1;
        end
        if (fill >= 2'd3 || msg_len < 2'd2) begin
            clear_message();
            return 1'b0;
        end
        held[fill] = b;
        fill++;
        if (fill >= msg_len) begin
            count = msg_len;
            cin   = msg_cin;
            fill  = 2'd0;
            if (run_status >= ST_SYSEX_START) begin
                clear_message();
            end
            ev = pack_event(cin, count);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // called at a rising edge; returns at the edge where the byte is taken
    task automatic push_midi(input t_byte b, input bit fixed, input bit fixed_hit,
                             input t_pkt want);
        t_usb_event ev;
        bit         hit;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            midi_valid <= 1'b0;
            @(posedge i_clk);
        end
        midi_valid <= 1'b1;
        midi_byte  <= b;
        @(posedge i_clk);
        while (!o_midi_ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        if (b != ST_RT_UNDEF_A && b != ST_RT_UNDEF_B) begin
            phase_items++;
        end
        hit = parse_midi_byte(b, ev);
        if (fixed) begin
            hit = fixed_hit;
            ev  = '{4'h0, want};
        end
        if (hit) begin
            pending_events.push_back(ev);
        end
    endtask

    task automatic write_cable(input t_nibble val);
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_cable <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        cfg_valid <= 1'b0;
        cable_cfg = val;
        cable_writes++;
    endtask

    function automatic t_byte data_byte();
        return t_byte'($urandom_range(0, 127));
    endfunction

    task automatic build_phrase();
        int    pick, reps, n;
        t_byte st;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            st = {4'($urandom_range(8, 14)), 4'($urandom)};
            phrase.push_back(st);
            reps = $urandom_range(1, 3);
            for (int r = 0; r < reps; r++) begin
                n = (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) ? 1 : 2;
                // now and then cut a message short
                if ($urandom_range(0, 9) == 0) n--;
                for (int k = 0; k < n; k++) phrase.push_back(data_byte());
            end
        end else if (pick < 60) begin
            case ($urandom_range(0, 3))
                0: begin
                    phrase.push_back(ST_MTC_QFRAME);
                    phrase.push_back(data_byte());
                end
                1: begin
                    phrase.push_back(ST_SONG_SEL);
                    phrase.push_back(data_byte());
                end
                2: begin
                    phrase.push_back(ST_SONG_POS);
                    phrase.push_back(data_byte());
                    phrase.push_back(data_byte());
                end
                default: phrase.push_back(ST_TUNE_REQ);
            endcase
            if ($urandom_range(0, 4) == 0) phrase.push_back(data_byte());
        end else if (pick < 85) begin
            phrase.push_back(ST_SYSEX_START);
            n = $urandom_range(0, 9);
            for (int k = 0; k < n; k++) phrase.push_back(data_byte());
            case ($urandom_range(0, 9))
                0:       phrase.push_back(t_byte'($urandom_range(8'h80, 8'hF6)));
                1:       phrase.push_back(t_byte'($urandom_range(8'hF4, 8'hF5)));
                default: phrase.push_back(ST_SYSEX_END);
            endcase
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) phrase.push_back(t_byte'($urandom_range(0, 255)));
        end
    endtask

    initial begin : pkt_sink
        int unsigned hold_left;
        t_usb_event  ev;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_pkt_valid && pkt_ready) begin
                if (pending_events.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected packet cin 0x%0h bytes %h %h %h", $time,
                             o_code_index, o_byte_one, o_byte_two, o_byte_three);
                end else begin
                    ev = pending_events.pop_front();
                    check_field("cable", ev.cable, o_cable);
                    check_field("code_index", ev.pkt.code_index, o_code_index);
                    check_field("byte_one", ev.pkt.byte_one, o_byte_one);
                    check_field("byte_two", ev.pkt.byte_two, o_byte_two);
                    check_field("byte_three", ev.pkt.byte_three, o_byte_three);
                    packets_seen++;
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pkt_ready <= 1'b0;
            end else begin
                pkt_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : midi_source
        int unsigned wait_n;
        t_nibble     cab;
        cable_cfg = 4'h0;
        clear_message();
        held = '{8'h00, 8'h00, 8'h00};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            push_midi(script[i].midi, script[i].fixed, script[i].fixed_hit, script[i].want);
        end
        midi_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       cab = 4'hF;
                1:       cab = 4'h0;
                default: cab = 4'($urandom);
            endcase
            write_cable(cab);
            steady      = (ph == 1);
            hold_req    = (ph == 2);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                build_phrase();
                while (phrase.size() != 0) begin
                    if ($urandom_range(0, 99) < 6) begin
                        push_midi(t_byte'($urandom_range(8'hF8, 8'hFF)), 1'b0, 1'b0, '0);
                    end
                    push_midi(phrase.pop_front(), 1'b0, 1'b0, '0);
                end
            end
            midi_valid <= 1'b0;
        end
        steady = 1'b0;

        for (wait_n = 0; wait_n < 5000 && pending_events.size() != 0; wait_n++) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            errors += pending_events.size();
            $display("%0t: %0d expected packets never arrived", $time, pending_events.size());
        end

        $display("Sent %0d MIDI bytes (scripted and random phrases), checked %0d packets",
                 bytes_sent, packets_seen);
        $display("Cable number written %0d times; one long output stall included",
                 cable_writes);
        if (errors == 0) begin
            $display("midi_byte_to_usb_midi_packet test passed");
        end else begin
            $display("midi_byte_to_usb_midi_packet test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/mbup_pkg.sv
rtl/core/mbup_in_stage.sv
rtl/core/mbup_parser.sv
rtl/core/midi_byte_to_usb_midi_packet.sv
verif/tb_midi_byte_to_usb_midi_packet.sv
